// ----- hdl/rgb_to_hsv_converter_unit_macros.svh -----
// Assertion macros shared by the RGB-to-HSV converter RTL.
// Depends on nothing; included by the files that carry concurrent checks.
`ifndef RGB_TO_HSV_CONVERTER_UNIT_MACROS_SVH
`define RGB_TO_HSV_CONVERTER_UNIT_MACROS_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define RHC_ASSERT_NOW(label, clk, rst_n, cond, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
		else $error("rgb_to_hsv_converter_unit: same-cycle check failed");

// Next-cycle implication, checked at every rising clock edge outside reset.
`define RHC_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
		else $error("rgb_to_hsv_converter_unit: next-cycle check failed");

`endif

// ----- hdl/rhc_pkg.sv -----
// Shared widths, scale constants and width functions for the RGB-to-HSV converter.
// Depends on nothing; every other file of the block but the macro header imports it.
package rhc_pkg;

	localparam int CH_W                  = 8;
	localparam int HUE_W                 = 15;
	localparam int HUE_FRACTION_BITS_DEF = 6;
	localparam int HUE_DEG_FULL          = 360;
	localparam int HUE_DEG_SECTOR        = 60;
	localparam int SAT_SCALE             = 255;

	// Bits of the rounded hue before wrapping: it can reach a full turn.
	function automatic int quot_w(input int frac_bits);
		return $clog2((HUE_DEG_FULL << frac_bits) + 1);
	endfunction

	// Remainder and shifted divisor width: divisor (2*channel) times 2^(quot_w-1).
	function automatic int rem_w(input int frac_bits);
		return quot_w(frac_bits) + CH_W + 1;
	endfunction

endpackage

// ----- hdl/rhc_rgb_if.sv -----
// Valid/ready channel that carries one RGB pixel per transaction.
// Depends on rhc_pkg for the channel width.
interface rhc_rgb_if;
	import rhc_pkg::*;

	logic            valid;
	logic            ready;
	logic [CH_W-1:0] red;
	logic [CH_W-1:0] green;
	logic [CH_W-1:0] blue;

	modport source (output valid, output red, output green, output blue, input ready);
	modport sink   (input valid, input red, input green, input blue, output ready);

endinterface

// ----- hdl/rhc_hsv_if.sv -----
// Valid/ready channel that carries one HSV pixel per transaction.
// Depends on rhc_pkg for the field widths.
interface rhc_hsv_if;
	import rhc_pkg::*;

	logic             valid;
	logic             ready;
	logic [HUE_W-1:0] hue;
	logic [CH_W-1:0]  saturation;
	logic [CH_W-1:0]  value;

	modport source (output valid, output hue, output saturation, output value, input ready);
	modport sink   (input valid, input hue, input saturation, input value, output ready);

endinterface

// ----- hdl/rhc_front.sv -----
// Input stage: max, min, spread, hue sector offset and both division operands.
// Depends on rhc_pkg and the rhc_rgb_if channel.
module rhc_front #(
	parameter int  HUE_FRACTION_BITS = rhc_pkg::HUE_FRACTION_BITS_DEF,
	localparam int QW                = rhc_pkg::quot_w(HUE_FRACTION_BITS),
	localparam int RW                = rhc_pkg::rem_w(HUE_FRACTION_BITS)
) (
	input  logic                    clk,
	input  logic                    arst_n,
	rhc_rgb_if.sink                 rgb,
	input  logic                    ready_dn,
	output logic                    valid_s1,
	output logic                    grey_s1,
	output logic [rhc_pkg::CH_W-1:0] value_s1,
	output logic [RW-1:0]           rem_sat_s1,
	output logic [RW-1:0]           rem_hue_s1,
	output logic [RW-1:0]           dv_sat_s1,
	output logic [RW-1:0]           dv_hue_s1
);
	import rhc_pkg::*;

	localparam int TW      = CH_W + 3;
	localparam int HUE_MUL = (2 * HUE_DEG_SECTOR) << HUE_FRACTION_BITS;
	localparam int SAT_MUL = 2 * SAT_SCALE;

	logic [CH_W-1:0] mx;
	logic [CH_W-1:0] mn;
	logic [CH_W-1:0] d;
	logic [TW-1:0]   t;
	logic [RW-1:0]   num_sat;
	logic [RW-1:0]   num_hue;
	logic [RW-1:0]   dv_sat;
	logic [RW-1:0]   dv_hue;

	always_comb begin
		mx = rgb.red;
		if (rgb.green > mx) mx = rgb.green;
		if (rgb.blue > mx) mx = rgb.blue;
		mn = rgb.red;
		if (rgb.green < mn) mn = rgb.green;
		if (rgb.blue < mn) mn = rgb.blue;
		d = mx - mn;

		// Sector offset in units of the spread; ties go to red, then green.
		// Every result lies in 0..6*spread, so modular arithmetic is exact.
		if (rgb.red >= mx) begin
			if (rgb.green >= rgb.blue) begin
				t = TW'(rgb.green) - TW'(rgb.blue);
			end else begin
				t = TW'({d, 2'b00}) + TW'({d, 1'b0}) + TW'(rgb.green) - TW'(rgb.blue);
			end
		end else if (rgb.green >= mx) begin
			t = TW'({d, 1'b0}) + TW'(rgb.blue) - TW'(rgb.red);
		end else begin
			t = TW'({d, 2'b00}) + TW'(rgb.red) - TW'(rgb.green);
		end

		// Round to nearest as floor((2*num + den) / (2*den)).
		num_hue = RW'(HUE_MUL) * RW'(t) + RW'(d);
		num_sat = RW'(SAT_MUL) * RW'(d) + RW'(mx);
		dv_hue  = RW'({d, 1'b0}) << (QW - 1);
		dv_sat  = RW'({mx, 1'b0}) << (QW - 1);
	end

	assign rgb.ready = !valid_s1 || ready_dn;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rgb.ready) begin
			valid_s1 <= rgb.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rgb.ready) begin
			grey_s1    <= (d == '0);
			value_s1   <= mx;
			rem_sat_s1 <= num_sat;
			rem_hue_s1 <= num_hue;
			dv_sat_s1  <= dv_sat;
			dv_hue_s1  <= dv_hue;
		end
	end

endmodule

// ----- hdl/rhc_div_cell.sv -----
// One cell of the division chain: resolves one quotient bit of saturation and of hue.
// Depends on rhc_pkg; cells are chained by the top level.
module rhc_div_cell #(
	parameter int  HUE_FRACTION_BITS = rhc_pkg::HUE_FRACTION_BITS_DEF,
	localparam int QW                = rhc_pkg::quot_w(HUE_FRACTION_BITS),
	localparam int RW                = rhc_pkg::rem_w(HUE_FRACTION_BITS)
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     valid_up,
	output logic                     ready_up,
	input  logic                     grey_up,
	input  logic [rhc_pkg::CH_W-1:0] value_up,
	input  logic [RW-1:0]            rem_sat_up,
	input  logic [RW-1:0]            rem_hue_up,
	input  logic [RW-1:0]            dv_sat_up,
	input  logic [RW-1:0]            dv_hue_up,
	input  logic [QW-1:0]            q_sat_up,
	input  logic [QW-1:0]            q_hue_up,
	input  logic                     ready_dn,
	output logic                     valid_q,
	output logic                     grey_q,
	output logic [rhc_pkg::CH_W-1:0] value_q,
	output logic [RW-1:0]            rem_sat_q,
	output logic [RW-1:0]            rem_hue_q,
	output logic [RW-1:0]            dv_sat_q,
	output logic [RW-1:0]            dv_hue_q,
	output logic [QW-1:0]            q_sat_q,
	output logic [QW-1:0]            q_hue_q
);
	import rhc_pkg::*;

	logic ge_sat;
	logic ge_hue;

	// Restoring step against the divisor aligned to this cell's quotient bit.
	assign ge_sat   = rem_sat_up >= dv_sat_up;
	assign ge_hue   = rem_hue_up >= dv_hue_up;
	assign ready_up = !valid_q || ready_dn;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ready_up) begin
			valid_q <= valid_up;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_up) begin
			grey_q    <= grey_up;
			value_q   <= value_up;
			rem_sat_q <= ge_sat ? rem_sat_up - dv_sat_up : rem_sat_up;
			rem_hue_q <= ge_hue ? rem_hue_up - dv_hue_up : rem_hue_up;
			dv_sat_q  <= dv_sat_up >> 1;
			dv_hue_q  <= dv_hue_up >> 1;
			q_sat_q   <= {q_sat_up[QW-2:0], ge_sat};
			q_hue_q   <= {q_hue_up[QW-2:0], ge_hue};
		end
	end

endmodule

// ----- hdl/rhc_back.sv -----
// Output stage: hue wrap, grey-pixel masking and the result register.
// Depends on rhc_pkg and the rhc_hsv_if channel.
module rhc_back #(
	parameter int  HUE_FRACTION_BITS = rhc_pkg::HUE_FRACTION_BITS_DEF,
	localparam int QW                = rhc_pkg::quot_w(HUE_FRACTION_BITS)
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     valid_up,
	output logic                     ready_up,
	input  logic                     grey_up,
	input  logic [rhc_pkg::CH_W-1:0] value_up,
	input  logic [QW-1:0]            q_sat_up,
	input  logic [QW-1:0]            q_hue_up,
	rhc_hsv_if.source                hsv
);
	import rhc_pkg::*;

	localparam logic [QW-1:0] HUE_TURN = QW'(HUE_DEG_FULL << HUE_FRACTION_BITS);

	logic                 valid_q;
	logic [HUE_W-1:0]     hue_q;
	logic [CH_W-1:0]      sat_q;
	logic [CH_W-1:0]      value_q;
	logic [QW-1:0]        hue_wrapped;

	// A hue that rounds up to a full turn is the same angle as zero.
	assign hue_wrapped = (q_hue_up >= HUE_TURN) ? q_hue_up - HUE_TURN : q_hue_up;
	assign ready_up    = !valid_q || hsv.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ready_up) begin
			valid_q <= valid_up;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_up) begin
			hue_q   <= grey_up ? '0 : HUE_W'(hue_wrapped);
			sat_q   <= grey_up ? '0 : q_sat_up[CH_W-1:0];
			value_q <= value_up;
		end
	end

	assign hsv.valid      = valid_q;
	assign hsv.hue        = hue_q;
	assign hsv.saturation = sat_q;
	assign hsv.value      = value_q;

endmodule

// ----- hdl/rgb_to_hsv_converter_unit.sv -----
// Top level of the RGB-to-HSV converter: input stage, division cell chain, output stage.
// Depends on rhc_pkg, rhc_rgb_if, rhc_hsv_if, rhc_front, rhc_div_cell, rhc_back.
//
//   Channel | Direction | Payload                            | Handshake
//   --------+-----------+------------------------------------+------------
//   rgb     | in        | red, green, blue (8 bits each)     | valid/ready
//   hsv     | out       | hue (15), saturation (8), value (8)| valid/ready
//
// While hsv is ready, the converter accepts one transaction per clock cycle and delivers one per cycle.
// The pipeline holds one input stage, one division cell per quotient bit, and one output register.
// Both divisions share the cell chain; each cell settles one quotient bit of each.
// Reset clears only the valid flags; data registers load without reset.
// A stall on hsv backs up through each stage only as far as the stages are full,
// so bubbles in the chain keep absorbing input transactions.
`include "rgb_to_hsv_converter_unit_macros.svh"

module rgb_to_hsv_converter_unit #(
	parameter int  HUE_FRACTION_BITS = rhc_pkg::HUE_FRACTION_BITS_DEF,
	localparam int QW                = rhc_pkg::quot_w(HUE_FRACTION_BITS),
	localparam int RW                = rhc_pkg::rem_w(HUE_FRACTION_BITS)
) (
	input  logic      clk,
	input  logic      arst_n,
	rhc_rgb_if.sink   rgb,
	rhc_hsv_if.source hsv
);
	import rhc_pkg::*;

	// Link i feeds cell i; link QW feeds the output stage.
	logic            valid_c   [0:QW];
	logic            ready_c   [0:QW];
	logic            grey_c    [0:QW];
	logic [CH_W-1:0] value_c   [0:QW];
	logic [RW-1:0]   rem_sat_c [0:QW];
	logic [RW-1:0]   rem_hue_c [0:QW];
	logic [RW-1:0]   dv_sat_c  [0:QW];
	logic [RW-1:0]   dv_hue_c  [0:QW];
	logic [QW-1:0]   q_sat_c   [0:QW];
	logic [QW-1:0]   q_hue_c   [0:QW];

	// The front stage computes the spread, the hue sector offset and the
	// rounded-division operands, with each divisor aligned to the top quotient bit.
	rhc_front #(
		.HUE_FRACTION_BITS(HUE_FRACTION_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.rgb       (rgb),
		.ready_dn  (ready_c[0]),
		.valid_s1  (valid_c[0]),
		.grey_s1   (grey_c[0]),
		.value_s1  (value_c[0]),
		.rem_sat_s1(rem_sat_c[0]),
		.rem_hue_s1(rem_hue_c[0]),
		.dv_sat_s1 (dv_sat_c[0]),
		.dv_hue_s1 (dv_hue_c[0])
	);

	// Quotients start empty and gain one bit per cell, most significant first.
	assign q_sat_c[0] = '0;
	assign q_hue_c[0] = '0;

	for (genvar i = 0; i < QW; i++) begin : g_cell
		rhc_div_cell #(
			.HUE_FRACTION_BITS(HUE_FRACTION_BITS)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.valid_up  (valid_c[i]),
			.ready_up  (ready_c[i]),
			.grey_up   (grey_c[i]),
			.value_up  (value_c[i]),
			.rem_sat_up(rem_sat_c[i]),
			.rem_hue_up(rem_hue_c[i]),
			.dv_sat_up (dv_sat_c[i]),
			.dv_hue_up (dv_hue_c[i]),
			.q_sat_up  (q_sat_c[i]),
			.q_hue_up  (q_hue_c[i]),
			.ready_dn  (ready_c[i+1]),
			.valid_q   (valid_c[i+1]),
			.grey_q    (grey_c[i+1]),
			.value_q   (value_c[i+1]),
			.rem_sat_q (rem_sat_c[i+1]),
			.rem_hue_q (rem_hue_c[i+1]),
			.dv_sat_q  (dv_sat_c[i+1]),
			.dv_hue_q  (dv_hue_c[i+1]),
			.q_sat_q   (q_sat_c[i+1]),
			.q_hue_q   (q_hue_c[i+1])
		);
	end

	// The back stage wraps a full-turn hue to zero and forces grey pixels to
	// zero hue and saturation before the output register.
	rhc_back #(
		.HUE_FRACTION_BITS(HUE_FRACTION_BITS)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.valid_up(valid_c[QW]),
		.ready_up(ready_c[QW]),
		.grey_up (grey_c[QW]),
		.value_up(value_c[QW]),
		.q_sat_up(q_sat_c[QW]),
		.q_hue_up(q_hue_c[QW]),
		.hsv     (hsv)
	);

	// After the last cell the remainder is below the original divisor 2*den,
	// and the divisor has been shifted back down to den.
	`RHC_ASSERT_NOW(a_hue_rem_bound, clk, arst_n, valid_c[QW] && !grey_c[QW], rem_hue_c[QW] < (dv_hue_c[QW] << 1))
	`RHC_ASSERT_NOW(a_sat_rem_bound, clk, arst_n, valid_c[QW] && !grey_c[QW], rem_sat_c[QW] < (dv_sat_c[QW] << 1))
	// Any nonzero spread gives a saturation of at least one, so zero means grey.
	`RHC_ASSERT_NOW(a_grey_hue_zero, clk, arst_n, hsv.valid && hsv.saturation == '0, hsv.hue == '0)
	`RHC_ASSERT_NOW(a_black_sat_zero, clk, arst_n, hsv.valid && hsv.value == '0, hsv.saturation == '0)
	`RHC_ASSERT_NEXT(a_accept_enters, clk, arst_n, rgb.valid && rgb.ready, valid_c[0])

endmodule
